FILE: rtl/core/mexp_pkg.sv
// Package for the modular exponentiation block.
// Holds the port field width, register index codes, controller state type and multiplier handshake types.
// No dependencies.
`default_nettype none

package mexp_pkg;

   // Width of every payload and configuration field at the ports
   localparam int FIELD_BITS = 32;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODULUS  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXPONENT = 1'b1;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SQUARE,
      ST_MULT
   } mexp_state_type;

   // Handshake between sequencer and the serial multiplier
   typedef struct packed {
      logic start;
   } mexp_mul_req_type;

   typedef struct packed {
      logic done;
   } mexp_mul_rsp_type;

endpackage

`default_nettype wire

FILE: rtl/core/mexp_mul.sv
// Bit-serial modular multiplier: result = (op_a * op_b) mod modulus.
// Interleaved form, one bit of op_a per cycle, MSB first. Uses mexp_pkg.
// op_b must already be below modulus; modulus zero wraps at WORD_BITS.
`default_nettype none

module mexp_mul #(
   parameter int WORD_BITS = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mexp_pkg::mexp_mul_req_type  req,
   input  wire logic [WORD_BITS-1:0]        op_a,
   input  wire logic [WORD_BITS-1:0]        op_b,
   input  wire logic [WORD_BITS-1:0]        modulus,
   output mexp_pkg::mexp_mul_rsp_type       rsp,
   output logic [WORD_BITS-1:0]             result
);
   import mexp_pkg::*;

   localparam int CNT_BITS = $clog2(WORD_BITS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] a_ff, a_in;
   logic [WORD_BITS-1:0] b_ff, b_in;
   logic [WORD_BITS-1:0] r_ff, r_in;

   logic [WORD_BITS+1:0] sum_w;
   logic [WORD_BITS+1:0] mod_x1;
   logic [WORD_BITS+1:0] mod_x2;
   logic [WORD_BITS+1:0] red_w;

   // One step: r = 2r + a_bit*b, then bring back below modulus (at most 2m off)
   always_comb begin
      sum_w  = {1'b0, r_ff, 1'b0} + {2'b00, (a_ff[WORD_BITS-1] ? b_ff : '0)};
      mod_x1 = {2'b00, modulus};
      mod_x2 = {1'b0, modulus, 1'b0};
      if (sum_w >= mod_x2) begin
         red_w = sum_w - mod_x2;
      end else if (sum_w >= mod_x1) begin
         red_w = sum_w - mod_x1;
      end else begin
         red_w = sum_w;
      end
   end

   // Operand shift register and step counter
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      r_in    = r_ff;
      if (busy_ff) begin
         r_in   = red_w[WORD_BITS-1:0];
         a_in   = {a_ff[WORD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(WORD_BITS);
         a_in    = op_a;
         b_in    = op_b;
         r_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      r_ff <= r_in;
   end

   assign rsp.done = done_ff;
   assign result   = r_ff;

endmodule

`default_nettype wire

FILE: rtl/core/modular_exponentiation_top.sv
// Top level of the modular exponentiation block: register file, sequencer.
// Instantiates mexp_mul; uses mexp_pkg.
//
// Channel   Ports                               Transfer
// request   start, busy, req_base               start high while busy low
// result    rsp_valid, rsp_power_mod            rsp_valid high, one cycle
// config    csr_we, csr_index, csr_wdata        csr_we high
//
// Zero exponent: the result appears in the cycle after the transfer.
// Otherwise square-and-multiply over all WORD_BITS exponent bits, MSB first,
// on one bit-serial multiplier: a reduction product, then a square for every
// exponent bit and a multiply for every set bit. The leading product reduces
// base below the modulus. One item at a time.
// Synchronous reset sets modulus and exponent to 1. Results cannot be held off.
`default_nettype none

module modular_exponentiation_top #(
   parameter int WORD_BITS = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [mexp_pkg::FIELD_BITS-1:0]       req_base,
   output logic                                       rsp_valid,
   output logic [mexp_pkg::FIELD_BITS-1:0]            rsp_power_mod,
   input  wire logic                                  csr_we,
   input  wire logic [mexp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [mexp_pkg::FIELD_BITS-1:0]       csr_wdata
);
   import mexp_pkg::*;

   localparam int CNT_BITS = $clog2(WORD_BITS + 1);

   mexp_state_type       state_ff, state_in;
   logic [WORD_BITS-1:0] modulus_ff, modulus_in;
   logic [WORD_BITS-1:0] exponent_ff, exponent_in;
   logic [WORD_BITS-1:0] exp_sr_ff, exp_sr_in;
   logic [CNT_BITS-1:0]  bit_cnt_ff, bit_cnt_in;
   logic [WORD_BITS-1:0] base_ff, base_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] rsp_data_ff, rsp_data_in;

   mexp_mul_req_type     mul_req;
   mexp_mul_rsp_type     mul_rsp;
   logic [WORD_BITS-1:0] mul_a;
   logic [WORD_BITS-1:0] mul_b;
   logic [WORD_BITS-1:0] mul_res;

   logic                 accept;
   logic                 last_bit;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign last_bit = (bit_cnt_ff == CNT_BITS'(1));

   // Configuration writes
   always_comb begin
      modulus_in  = modulus_ff;
      exponent_in = exponent_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MODULUS:  modulus_in  = csr_wdata[WORD_BITS-1:0];
            CSR_EXPONENT: exponent_in = csr_wdata[WORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (exponent_ff != '0)) state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (mul_rsp.done) state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            if (mul_rsp.done) begin
               if (exp_sr_ff[WORD_BITS-1]) state_in = ST_MULT;
               else if (last_bit)          state_in = ST_IDLE;
            end
         end
         ST_MULT: begin
            if (mul_rsp.done) state_in = last_bit ? ST_IDLE : ST_SQUARE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath control and multiplier launches
   always_comb begin
      exp_sr_in    = exp_sr_ff;
      bit_cnt_in   = bit_cnt_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      mul_req      = '0;
      mul_a        = mul_res;
      mul_b        = mul_res;
      unique case (state_ff)
         ST_IDLE: begin
            mul_a = req_base[WORD_BITS-1:0];
            mul_b = WORD_BITS'(1);
            if (accept) begin
               exp_sr_in  = exponent_ff;
               bit_cnt_in = CNT_BITS'(WORD_BITS);
               acc_in     = (modulus_ff == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
               if (exponent_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = WORD_BITS'(1);
               end else begin
                  mul_req.start = 1'b1;
               end
            end
         end
         ST_REDUCE: begin
            mul_a = acc_ff;
            mul_b = acc_ff;
            if (mul_rsp.done) begin
               base_in       = mul_res;
               mul_req.start = 1'b1;
            end
         end
         ST_SQUARE: begin
            mul_a = mul_res;
            mul_b = exp_sr_ff[WORD_BITS-1] ? base_ff : mul_res;
            if (mul_rsp.done) begin
               acc_in = mul_res;
               if (exp_sr_ff[WORD_BITS-1]) begin
                  mul_req.start = 1'b1;
               end else if (last_bit) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = mul_res;
               end else begin
                  exp_sr_in     = {exp_sr_ff[WORD_BITS-2:0], 1'b0};
                  bit_cnt_in    = bit_cnt_ff - CNT_BITS'(1);
                  mul_req.start = 1'b1;
               end
            end
         end
         ST_MULT: begin
            if (mul_rsp.done) begin
               acc_in = mul_res;
               if (last_bit) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = mul_res;
               end else begin
                  exp_sr_in     = {exp_sr_ff[WORD_BITS-2:0], 1'b0};
                  bit_cnt_in    = bit_cnt_ff - CNT_BITS'(1);
                  mul_req.start = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         modulus_ff   <= WORD_BITS'(1);
         exponent_ff  <= WORD_BITS'(1);
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         exponent_ff  <= exponent_in;
         bit_cnt_ff   <= bit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      exp_sr_ff   <= exp_sr_in;
      base_ff     <= base_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   mexp_mul #(
      .WORD_BITS (WORD_BITS)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .req     (mul_req),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (modulus_ff),
      .rsp     (mul_rsp),
      .result  (mul_res)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_power_mod = FIELD_BITS'(rsp_data_ff);

endmodule

`default_nettype wire
